@@ design/hashed_key_value_store_unit_defines.svh @@
// assertion macros for the hashed key-value store unit
// no dependencies; taken in by the top level
`ifndef HASHED_KEY_VALUE_STORE_UNIT_DEFINES_SVH
`define HASHED_KEY_VALUE_STORE_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define HKVS_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("hkvs check failed");

// next-cycle implication under reset
`define HKVS_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("hkvs check failed");

`endif

@@ design/hkvs_pkg.sv @@
// shared types, constants and helpers for the hashed key-value store
// no dependencies
`default_nettype none

package hkvs_pkg;

    localparam int DEF_BUCKETS     = 256;
    localparam int DEF_ENTRIES     = 64;
    localparam int DEF_KEY_BYTES   = 8;
    localparam int DEF_VALUE_BYTES = 8;

    localparam int DATA_W      = 64;
    localparam int COUNT_OUT_W = 7;
    localparam logic [DATA_W-1:0] HASH_SEED = 64'd5381;
    localparam int HASH_SHIFT  = 5;
    localparam int HASH_STEPS  = 8;
    localparam int MOD_BITS    = 4;
    localparam int MOD_STEPS   = DATA_W / MOD_BITS;
    localparam int STEP_W      = 4;

    typedef enum logic [1:0] {
        REQ_SET = 2'd0,
        REQ_GET = 2'd1,
        REQ_DEL = 2'd2,
        REQ_REN = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EXISTS   = 2'd3
    } status_t;

    typedef struct packed {
        logic    capture;
        logic    clr_step;
        logic    hash_init;
        logic    hash_step;
        logic    mod_init;
        logic    mod_step;
        logic    head_ld;
        logic    sel_scan;
        logic    walk_adv;
        logic    save1;
        logic    scan_init;
        logic    scan_adv;
        logic    do_insert;
        logic    ins_rename;
        logic    do_update;
        logic    do_unlink;
        logic    res_load;
        status_t res_status;
        logic    res_found;
        logic    res_value;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        req_t op;
        logic walk_ok;
        logic match;
        logic count_full;
        logic scan_free;
        logic scan_last;
        logic clr_last;
    } stat_t;

    // keep the low nbytes bytes up to the first zero byte
    function automatic logic [DATA_W-1:0] canon(input logic [DATA_W-1:0] x, input int nbytes);
        logic [DATA_W-1:0] r;
        logic              keep;
        r    = '0;
        keep = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (keep && (i < nbytes) && (x[8*i +: 8] != 8'd0))
            begin
                r[8*i +: 8] = x[8*i +: 8];
            end
            else
            begin
                keep = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/hkvs_ctrl.sv @@
// request sequencer for the hashed key-value store
// depends on hkvs_pkg
`default_nettype none

module hkvs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    output hkvs_pkg::cmd_t     cmd,
    input  wire hkvs_pkg::stat_t st
);
    import hkvs_pkg::*;

    typedef enum logic [14:0] {
        S_CLEAR     = 15'h0001,
        S_IDLE      = 15'h0002,
        S_HASH      = 15'h0004,
        S_MOD       = 15'h0008,
        S_HEAD_RD   = 15'h0010,
        S_HEAD_LD   = 15'h0020,
        S_WALK_TEST = 15'h0040,
        S_WALK_RD   = 15'h0080,
        S_WALK_CMP  = 15'h0100,
        S_DECIDE    = 15'h0200,
        S_UNLINK    = 15'h0400,
        S_SCAN_RD   = 15'h0800,
        S_SCAN_CHK  = 15'h1000,
        S_INSERT    = 15'h2000,
        S_DONE      = 15'h4000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic                pass2_reg, pass2_next;
    logic                hit_reg, hit_next;
    logic                out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pass2_next = pass2_reg;
        hit_next   = hit_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    pass2_next  = 1'b0;
                    state_next  = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(HASH_STEPS - 1))
                begin
                    cmd.mod_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(MOD_STEPS - 1))
                begin
                    state_next = S_HEAD_RD;
                end
            end
            S_HEAD_RD:
            begin
                state_next = S_HEAD_LD;
            end
            S_HEAD_LD:
            begin
                cmd.head_ld = 1'b1;
                hit_next    = 1'b0;
                state_next  = S_WALK_TEST;
            end
            S_WALK_TEST:
            begin
                state_next = st.walk_ok ? S_WALK_RD : S_DECIDE;
            end
            S_WALK_RD:
            begin
                state_next = S_WALK_CMP;
            end
            S_WALK_CMP:
            begin
                if (st.match)
                begin
                    hit_next   = 1'b1;
                    cmd.save1  = !pass2_reg;
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd.walk_adv = 1'b1;
                    state_next   = S_WALK_TEST;
                end
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (pass2_reg)
                begin
                    if (hit_reg)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_EXISTS;
                        cmd.res_found  = 1'b1;
                    end
                    else
                    begin
                        state_next = S_UNLINK;
                    end
                end
                else
                begin
                    case (st.op)
                        REQ_SET:
                        begin
                            if (hit_reg)
                            begin
                                cmd.do_update  = 1'b1;
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_OK;
                                cmd.res_found  = 1'b1;
                            end
                            else if (st.count_full)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.scan_init = 1'b1;
                                state_next    = S_SCAN_RD;
                            end
                        end
                        REQ_GET:
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = hit_reg ? ST_OK : ST_NOTFOUND;
                            cmd.res_found  = hit_reg;
                            cmd.res_value  = hit_reg;
                        end
                        REQ_DEL:
                        begin
                            if (hit_reg)
                            begin
                                state_next = S_UNLINK;
                            end
                            else
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_NOTFOUND;
                            end
                        end
                        REQ_REN:
                        begin
                            if (hit_reg)
                            begin
                                cmd.hash_init = 1'b1;
                                pass2_next    = 1'b1;
                                cnt_next      = '0;
                                state_next    = S_HASH;
                            end
                            else
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_NOTFOUND;
                            end
                        end
                        default:
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_NOTFOUND;
                        end
                    endcase
                end
            end
            S_UNLINK:
            begin
                cmd.do_unlink = 1'b1;
                if (pass2_reg)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN_RD;
                end
                else
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_found  = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_SCAN_RD:
            begin
                cmd.sel_scan = 1'b1;
                state_next   = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.sel_scan = 1'b1;
                if (st.scan_free)
                begin
                    state_next = S_INSERT;
                end
                else if (st.scan_last)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_FULL;
                    cmd.res_found  = pass2_reg;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_INSERT:
            begin
                cmd.sel_scan   = 1'b1;
                cmd.do_insert  = 1'b1;
                cmd.ins_rename = pass2_reg;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_found  = pass2_reg;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            pass2_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pass2_reg     <= pass2_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ design/hkvs_dp.sv @@
// datapath of the hashed key-value store: hash, bucket reduction, tables
// depends on hkvs_pkg
`default_nettype none

module hkvs_dp #(
    parameter int BUCKETS     = hkvs_pkg::DEF_BUCKETS,
    parameter int ENTRIES     = hkvs_pkg::DEF_ENTRIES,
    parameter int KEY_BYTES   = hkvs_pkg::DEF_KEY_BYTES,
    parameter int VALUE_BYTES = hkvs_pkg::DEF_VALUE_BYTES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [1:0]                        req_type,
    input  wire logic [hkvs_pkg::DATA_W-1:0]       key,
    input  wire logic [hkvs_pkg::DATA_W-1:0]       value,
    input  wire logic [hkvs_pkg::DATA_W-1:0]       new_key,
    input  wire hkvs_pkg::cmd_t                    cmd,
    output hkvs_pkg::stat_t                        st,
    output logic [1:0]                             status,
    output logic                                   found,
    output logic [hkvs_pkg::DATA_W-1:0]            read_value,
    output logic [hkvs_pkg::COUNT_OUT_W-1:0]       entry_count
);
    import hkvs_pkg::*;

    localparam int BW   = $clog2(BUCKETS);
    localparam int SW   = $clog2(ENTRIES);
    localparam int IW   = $clog2(ENTRIES + 1);
    localparam int CLRN = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
    localparam int CLRW = $clog2(CLRN);
    localparam int KW   = 8 * KEY_BYTES;
    localparam int VW   = 8 * VALUE_BYTES;
    localparam logic [IW-1:0] NIL    = IW'(ENTRIES);
    localparam logic [BW:0]   BUCK_C = (BW + 1)'(BUCKETS);

    // tables
    logic [IW-1:0] head_mem  [BUCKETS];
    logic [KW-1:0] key_mem   [ENTRIES];
    logic [VW-1:0] val_mem   [ENTRIES];
    logic [IW-1:0] next_mem  [ENTRIES];
    logic          valid_mem [ENTRIES];

    logic [IW-1:0] head_rd_reg;
    logic [KW-1:0] key_rd_reg;
    logic [VW-1:0] val_rd_reg;
    logic [IW-1:0] next_rd_reg;
    logic          valid_rd_reg;

    // request and walk registers
    req_t              op_reg;
    logic [KW-1:0]     tgt_reg, nk_reg;
    logic [VW-1:0]     v_reg;
    logic [DATA_W-1:0] h_reg, hk_reg;
    logic [BW-1:0]     r_reg, r_next;
    logic [IW-1:0]     head_reg, cur_reg, prev_reg, steps_reg;
    logic [SW-1:0]     scan_reg;
    logic [SW-1:0]     e1_reg;
    logic [IW-1:0]     prev1_reg, nxt1_reg;
    logic [VW-1:0]     val1_reg;
    logic [BW-1:0]     bk1_reg;
    status_t           res_status_reg;
    logic              res_found_reg;
    logic [VW-1:0]     res_value_reg;
    status_t           status_reg;
    logic              found_reg;
    logic [DATA_W-1:0] rvalue_reg;
    logic [COUNT_OUT_W-1:0] ecount_reg;

    logic [CLRW-1:0]   clr_reg;
    logic [IW-1:0]     count_reg;

    logic [DATA_W-1:0] kc, vc, nkc, h_step;
    logic [7:0]        hbyte;
    logic [SW-1:0]     slot_ra;
    logic [IW-1:0]     ins_head;
    logic              unlink_head;

    assign kc  = canon(key, KEY_BYTES);
    assign vc  = canon(value, VALUE_BYTES);
    assign nkc = canon(new_key, KEY_BYTES);

    // djb2 step, one byte per cycle; zero bytes only follow the key
    assign hbyte  = hk_reg[7:0];
    assign h_step = (hbyte != 8'd0)
                  ? ((h_reg << HASH_SHIFT) + h_reg + DATA_W'(hbyte)) : h_reg;

    // remainder by the bucket count, MOD_BITS bits per cycle, msb first
    always_comb
    begin
        logic [BW:0] rr;
        rr = {1'b0, r_reg};
        for (int i = 0; i < MOD_BITS; i++)
        begin
            rr = {rr[BW-1:0], h_reg[DATA_W-1-i]};
            if (rr >= BUCK_C)
            begin
                rr = rr - BUCK_C;
            end
        end
        r_next = rr[BW-1:0];
    end

    assign slot_ra     = cmd.sel_scan ? scan_reg : cur_reg[SW-1:0];
    assign unlink_head = (prev1_reg >= NIL);
    assign ins_head    = (cmd.ins_rename && (bk1_reg == r_reg) && unlink_head)
                       ? nxt1_reg : head_reg;

    // bucket heads
    always_ff @(posedge clk)
    begin
        head_rd_reg <= head_mem[r_reg];
        if (cmd.clr_step && (clr_reg < BUCKETS))
        begin
            head_mem[BW'(clr_reg)] <= NIL;
        end
        else if (cmd.do_insert)
        begin
            head_mem[r_reg] <= IW'(scan_reg);
        end
        else if (cmd.do_unlink && unlink_head)
        begin
            head_mem[bk1_reg] <= nxt1_reg;
        end
    end

    // entry pool
    always_ff @(posedge clk)
    begin
        key_rd_reg  <= key_mem[slot_ra];
        val_rd_reg  <= val_mem[slot_ra];
        next_rd_reg <= next_mem[slot_ra];
        if (cmd.do_insert)
        begin
            key_mem[scan_reg]  <= tgt_reg;
            val_mem[scan_reg]  <= cmd.ins_rename ? val1_reg : v_reg;
            next_mem[scan_reg] <= ins_head;
        end
        else if (cmd.do_update)
        begin
            val_mem[e1_reg] <= v_reg;
        end
        else if (cmd.do_unlink && !unlink_head)
        begin
            next_mem[prev1_reg[SW-1:0]] <= nxt1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        valid_rd_reg <= valid_mem[slot_ra];
        if (cmd.clr_step && (clr_reg < ENTRIES))
        begin
            valid_mem[SW'(clr_reg)] <= 1'b0;
        end
        else if (cmd.do_insert)
        begin
            valid_mem[scan_reg] <= 1'b1;
        end
        else if (cmd.do_unlink)
        begin
            valid_mem[e1_reg] <= 1'b0;
        end
    end

    // sweep pointer and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.do_insert)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.do_unlink && (count_reg != '0))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= req_t'(req_type);
            tgt_reg <= kc[KW-1:0];
            nk_reg  <= nkc[KW-1:0];
            v_reg   <= vc[VW-1:0];
            h_reg   <= HASH_SEED;
            hk_reg  <= kc;
        end
        else if (cmd.hash_init)
        begin
            tgt_reg <= nk_reg;
            h_reg   <= HASH_SEED;
            hk_reg  <= DATA_W'(nk_reg);
        end
        else if (cmd.hash_step)
        begin
            h_reg  <= h_step;
            hk_reg <= hk_reg >> 8;
        end
        else if (cmd.mod_step)
        begin
            h_reg <= h_reg << MOD_BITS;
        end

        if (cmd.mod_init)
        begin
            r_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            r_reg <= r_next;
        end

        if (cmd.head_ld)
        begin
            head_reg  <= head_rd_reg;
            cur_reg   <= head_rd_reg;
            prev_reg  <= NIL;
            steps_reg <= '0;
        end
        else if (cmd.walk_adv)
        begin
            prev_reg  <= cur_reg;
            cur_reg   <= next_rd_reg;
            steps_reg <= steps_reg + 1'b1;
        end

        if (cmd.save1)
        begin
            e1_reg    <= cur_reg[SW-1:0];
            prev1_reg <= prev_reg;
            nxt1_reg  <= next_rd_reg;
            val1_reg  <= val_rd_reg;
            bk1_reg   <= r_reg;
        end

        if (cmd.scan_init)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_adv)
        begin
            scan_reg <= scan_reg + 1'b1;
        end

        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_found_reg  <= cmd.res_found;
            res_value_reg  <= cmd.res_value ? val1_reg : '0;
        end

        if (cmd.out_load)
        begin
            status_reg <= res_status_reg;
            found_reg  <= res_found_reg;
            rvalue_reg <= DATA_W'(res_value_reg);
            ecount_reg <= COUNT_OUT_W'(count_reg);
        end
    end

    always_comb
    begin
        st            = '0;
        st.op         = op_reg;
        st.walk_ok    = (cur_reg < NIL) && (steps_reg < NIL);
        st.match      = valid_rd_reg && (key_rd_reg == tgt_reg);
        st.count_full = (count_reg >= NIL);
        st.scan_free  = !valid_rd_reg;
        st.scan_last  = (scan_reg == SW'(ENTRIES - 1));
        st.clr_last   = (clr_reg == CLRW'(CLRN - 1));
    end

    assign status      = status_reg;
    assign found       = found_reg;
    assign read_value  = rvalue_reg;
    assign entry_count = ecount_reg;

endmodule

`default_nettype wire

@@ design/hashed_key_value_store_unit.sv @@
// top level of the hashed key-value store: sequencer plus datapath
// depends on hkvs_pkg, hkvs_ctrl, hkvs_dp and the assertion macro header
`default_nettype none
`include "hashed_key_value_store_unit_defines.svh"

// Chained hash table holding up to ENTRIES key/value pairs of up to eight bytes each.
// A request (set, get, delete or rename) is taken when in_valid is high and in_stall
// low, and gives exactly one result transfer on the output side. Keys and values are
// cut at their first zero byte. The key is hashed with djb2 one byte a cycle, reduced
// modulo BUCKETS four bits a cycle, then the bucket chain is walked through a test, a
// read and a compare state per entry visited because every table is a memory with a
// registered read port. Rename runs the hash and walk twice, and an insert scans the
// slots from the lowest for the first free one, through a read and a check state per
// slot. One request is in flight at a time; a finished result may wait in the output
// register while the next request is taken. After reset the block sweeps bucket heads
// and valid marks with in_stall high.
module hashed_key_value_store_unit #(
    parameter int BUCKETS     = hkvs_pkg::DEF_BUCKETS,
    parameter int ENTRIES     = hkvs_pkg::DEF_ENTRIES,
    parameter int KEY_BYTES   = hkvs_pkg::DEF_KEY_BYTES,
    parameter int VALUE_BYTES = hkvs_pkg::DEF_VALUE_BYTES
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         req_type,
    input  wire logic [hkvs_pkg::DATA_W-1:0]        key,
    input  wire logic [hkvs_pkg::DATA_W-1:0]        value,
    input  wire logic [hkvs_pkg::DATA_W-1:0]        new_key,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [1:0]                              status,
    output logic                                    found,
    output logic [hkvs_pkg::DATA_W-1:0]             read_value,
    output logic [hkvs_pkg::COUNT_OUT_W-1:0]        entry_count
);
    import hkvs_pkg::*;

    // command and status groups between sequencer and datapath
    cmd_t  cmd;
    stat_t st;

    hkvs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .st        (st)
    );

    hkvs_dp #(
        .BUCKETS     (BUCKETS),
        .ENTRIES     (ENTRIES),
        .KEY_BYTES   (KEY_BYTES),
        .VALUE_BYTES (VALUE_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_type    (req_type),
        .key         (key),
        .value       (value),
        .new_key     (new_key),
        .cmd         (cmd),
        .st          (st),
        .status      (status),
        .found       (found),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

    // an insert only ever lands on a slot seen free by the scan
    `HKVS_ASSERT_IMP(a_insert_free, clk, rst_n, cmd.do_insert, st.scan_free)
    // a taken request keeps the input side closed on the next cycle
    `HKVS_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)
    // a miss reports neither a found flag nor a value
    `HKVS_ASSERT_IMP(a_miss_clean, clk, rst_n, out_valid && (status == ST_NOTFOUND), !found && (read_value == '0))

endmodule

`default_nettype wire
